// File: rtl/core/crki_pkg.sv
// ----------------------------------------------------------------------------
// crki_pkg: shared types and constants of the keyframe interpolator
// Holds field widths, the controller state type and controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package crki_pkg;

  localparam int unsigned DefMaxPoints = 256;
  localparam int unsigned CoordW       = 32;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned CountW       = 9;
  localparam int unsigned FracW        = 16;
  localparam int unsigned ParamW       = 17;
  localparam int unsigned AccW         = 40;

  localparam logic ActLoad  = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ONE_WAIT,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SEG_RD,
    ST_SEG_WAIT,
    ST_DIV_INIT,
    ST_DIV,
    ST_PTS_RD,
    ST_EVAL,
    ST_OUT
  } state_t;

  // point fetch slot selects
  typedef enum logic [1:0] {
    PT_I0,
    PT_SEG,
    PT_I1,
    PT_I2
  } ptsel_t;

  typedef struct packed {
    logic   start;       // latch query and set search bounds
    logic   srch_rd;     // read time at mid
    logic   srch_cmp;    // narrow search bounds
    logic   seg_rd;      // read t0 and t1
    logic   div_start;   // set up local parameter
    logic   div_step;    // one quotient bit
    logic   pt_rd;       // read one point
    ptsel_t pt_sel;
    logic   pt_cap;      // capture previous point read
    ptsel_t cap_sel;
    logic   eval_start;
    logic   eval_step;
    logic   single;      // one keyframe answer
  } dp_cmd_t;

  typedef struct packed {
    logic srch_done;
    logic div_done;
    logic eval_done;
  } dp_stat_t;

endpackage

// File: rtl/core/crki_ram.sv
// ----------------------------------------------------------------------------
// crki_ram: generic single-port-write, registered-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crki_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/crki_ctrl.sv
// ----------------------------------------------------------------------------
// crki_ctrl: query sequencer
// Steps through search, divide, point fetch and cubic evaluation.
// ----------------------------------------------------------------------------
module crki_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_go,      // query accepted
  input  logic              cnt_zero,
  input  logic              cnt_one,
  input  logic              out_taken,
  input  crki_pkg::dp_stat_t stat,
  output crki_pkg::dp_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  import crki_pkg::*;

  state_t     state, state_next;
  logic [2:0] pcnt, pcnt_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pcnt  <= '0;
    end else begin
      state <= state_next;
      pcnt  <= pcnt_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    pcnt_next  = pcnt;
    case (state)
      ST_IDLE: begin
        if (in_go && !cnt_zero) begin
          state_next = cnt_one ? ST_ONE_WAIT : ST_SRCH_RD;
        end
      end
      ST_ONE_WAIT: state_next = ST_OUT;
      ST_SRCH_RD:  state_next = ST_SRCH_CMP;
      ST_SRCH_CMP: state_next = stat.srch_done ? ST_SEG_RD : ST_SRCH_RD;
      ST_SEG_RD:   state_next = ST_SEG_WAIT;
      ST_SEG_WAIT: state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = ST_DIV;
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_PTS_RD;
          pcnt_next  = '0;
        end
      end
      ST_PTS_RD: begin
        pcnt_next = pcnt + 3'd1;
        if (pcnt == 3'd5) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: state_next = stat.eval_done ? ST_OUT : ST_EVAL;
      ST_OUT:  state_next = out_taken ? ST_IDLE : ST_OUT;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    busy       = (state != ST_IDLE);
    out_valid  = (state == ST_OUT);
    case (state)
      ST_IDLE: begin
        cmd.start  = in_go;
        cmd.single = in_go && cnt_one;
      end
      ST_SRCH_RD:  cmd.srch_rd = 1'b1;
      ST_SRCH_CMP: cmd.srch_cmp = 1'b1;
      ST_SEG_RD:   cmd.seg_rd = 1'b1;
      ST_DIV_INIT: cmd.div_start = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_PTS_RD: begin
        cmd.pt_rd   = (pcnt < 3'd4);
        cmd.pt_sel  = ptsel_t'(pcnt[1:0]);
        cmd.pt_cap  = (pcnt != 3'd0) && (pcnt < 3'd5);
        cmd.cap_sel = ptsel_t'(pcnt[1:0] - 2'd1);
        cmd.eval_start = (pcnt == 3'd5);
      end
      ST_EVAL:     cmd.eval_step = 1'b1;
      default: ;
    endcase
  end

  // assertions
  a_out_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> busy) else $error("result valid while idle");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_taken |=> out_valid) else $error("result dropped");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.start) else $error("start while busy");

endmodule

// File: rtl/core/crki_dp.sv
// ----------------------------------------------------------------------------
// crki_dp: interpolator datapath
// Keyframe memories, search bounds, bit-serial divider and a shared
// multiplier that runs the Horner steps for three coordinates in turn.
// ----------------------------------------------------------------------------
module crki_dp #(
  parameter int unsigned MaxPoints = crki_pkg::DefMaxPoints
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load_we,
  input  logic [7:0]                  load_idx,
  input  logic [crki_pkg::TimeW-1:0]  load_time,
  input  logic [3*crki_pkg::CoordW-1:0] load_pt,
  input  logic [crki_pkg::TimeW-1:0]  query_time,
  input  logic [crki_pkg::CountW-1:0] point_count,
  input  crki_pkg::dp_cmd_t           cmd,
  output crki_pkg::dp_stat_t          stat,
  output logic [3*crki_pkg::CoordW-1:0] result
);
  import crki_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxPoints);
  localparam int unsigned CW   = $clog2(MaxPoints + 1);

  // ---------------- memories
  logic            t_we;
  logic [IdxW-1:0] t_waddr, t_raddr, p_raddr;
  logic [TimeW-1:0] t_rdata;
  logic [3*CoordW-1:0] p_rdata;
  logic            idx_ok;

  assign idx_ok  = ({24'd0, load_idx} < 32'(MaxPoints));
  assign t_we    = load_we && idx_ok;
  assign t_waddr = IdxW'(load_idx);

  crki_ram #(.Width(TimeW), .Depth(MaxPoints)) u_time (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(load_time),
    .raddr(t_raddr), .rdata(t_rdata));

  crki_ram #(.Width(3*CoordW), .Depth(MaxPoints)) u_pts (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(load_pt),
    .raddr(p_raddr), .rdata(p_rdata));

  // ---------------- search
  logic [TimeW-1:0] u;
  logic [CW-1:0]    cnt, last, lo, hi, mid, seg, i0, i1, i2;
  logic [TimeW-1:0] t0;
  logic             seg_phase;  // 0 reading t0, 1 got t0

  assign cnt  = (32'(point_count) > 32'(MaxPoints)) ? CW'(MaxPoints) : CW'(point_count);
  assign last = cnt - CW'(1);
  assign mid  = CW'((32'(lo) + 32'(hi)) >> 1);
  assign seg  = (lo != '0) ? lo - CW'(1) : '0;
  assign i0   = (seg != '0) ? seg - CW'(1) : '0;
  assign i1   = seg + CW'(1);
  assign i2   = (i1 + CW'(1) > last) ? last : i1 + CW'(1);
  assign stat.srch_done = (lo >= hi) || (cmd.srch_cmp &&
    (((t_rdata < u) ? mid + CW'(1) : lo) >= ((t_rdata < u) ? hi : mid)));

  // memory read address
  always_comb begin
    t_raddr = IdxW'(mid);
    if (cmd.seg_rd) t_raddr = IdxW'(seg);
    if (seg_phase)  t_raddr = IdxW'(i1);
    case (cmd.pt_sel)
      PT_I0:   p_raddr = IdxW'(i0);
      PT_SEG:  p_raddr = IdxW'(seg);
      PT_I1:   p_raddr = IdxW'(i1);
      PT_I2:   p_raddr = IdxW'(i2);
      default: p_raddr = '0;
    endcase
    if (cmd.single) p_raddr = '0;
  end

  // search bounds
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      u  <= query_time;
      lo <= '0;
      hi <= last;
    end else if (cmd.srch_cmp && lo < hi) begin
      if (t_rdata < u) lo <= mid + CW'(1);
      else             hi <= mid;
    end
  end

  // t0 capture; t0 read issued in seg_rd, t1 issued the cycle after
  always_ff @(posedge clk) begin
    if (rst) seg_phase <= 1'b0;
    else     seg_phase <= cmd.seg_rd;
    if (seg_phase) t0 <= t_rdata;
  end

  // ---------------- divider, restoring, one bit a cycle
  logic [TimeW-1:0]  dden;
  logic [TimeW:0]    rem;
  logic [ParamW-1:0] s;
  logic [4:0]        dcnt;
  logic              dbusy;
  logic [TimeW+1:0]  rtry;
  logic [TimeW:0]    rsh;

  assign rsh  = {rem[TimeW-1:0], 1'b0};
  assign rtry = {1'b0, rsh} - {2'b0, dden};
  assign stat.div_done = !dbusy;

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
    end else if (cmd.div_start) begin
      // t1 on t_rdata now
      dden <= t_rdata - t0;
      rem  <= {1'b0, u - t0};
      dcnt <= 5'd0;
      if (u <= t0) begin
        s <= '0; dbusy <= 1'b0;
      end else if (u >= t_rdata) begin
        s <= ParamW'(1) << FracW; dbusy <= 1'b0;
      end else begin
        s <= '0; dbusy <= 1'b1;
      end
    end else if (cmd.div_step && dbusy) begin
      // remainder < divisor so quotient of rem*2^16 fits 16 bits
      if (!rtry[TimeW+1]) begin
        rem <= rtry[TimeW:0];
        s   <= {s[ParamW-2:0], 1'b1};
      end else begin
        rem <= rsh;
        s   <= {s[ParamW-2:0], 1'b0};
      end
      dcnt <= dcnt + 5'd1;
      if (dcnt == 5'd15) dbusy <= 1'b0;
    end
  end

  // ---------------- point capture
  logic [3*CoordW-1:0] pts [4];

  always_ff @(posedge clk) begin
    if (cmd.pt_cap) pts[cmd.cap_sel] <= p_rdata;
  end

  // ---------------- Horner evaluation, shared multiplier
  logic signed [AccW-1:0] coa [3], cob [3], coc [3];
  logic signed [AccW-1:0] acc;
  logic [1:0]             ci;     // coordinate
  logic [1:0]             hstep;  // 0..2 multiply steps
  logic                   ebusy;
  logic signed [AccW+ParamW:0]  prod;
  logic signed [AccW+ParamW:0]  rsum;
  logic signed [AccW-1:0]       rnd;
  logic signed [AccW-1:0]       addend;
  logic signed [AccW-1:0]       fin;
  logic signed [AccW-1:0]       half;
  logic signed [CoordW-1:0]     p1c;
  logic                         single_d;

  // coefficients per coordinate
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic signed [AccW-1:0] p0, p1, p2, p3, m0, m1, d;
      p0 = AccW'($signed(pts[PT_I0][c*CoordW +: CoordW]));
      p1 = AccW'($signed(pts[PT_SEG][c*CoordW +: CoordW]));
      p2 = AccW'($signed(pts[PT_I1][c*CoordW +: CoordW]));
      p3 = AccW'($signed(pts[PT_I2][c*CoordW +: CoordW]));
      m0 = p2 - p0;
      m1 = p3 - p1;
      d  = p1 - p2;
      coa[c] = (d <<< 2) + m0 + m1;
      cob[c] = -(d <<< 2) - (d <<< 1) - (m0 <<< 1) - m1;
      coc[c] = m0;
    end
  end

  assign prod = (AccW+ParamW+1)'(acc) * $signed({1'b0, s});
  assign rsum = prod + (AccW+ParamW+1)'(32768);
  assign rnd  = AccW'(rsum >>> FracW);
  always_comb begin
    case (hstep)
      2'd0:    addend = cob[ci];
      2'd1:    addend = coc[ci];
      default: addend = '0;
    endcase
  end
  assign p1c  = $signed(pts[PT_SEG][ci*CoordW +: CoordW]);
  assign half = (rnd + AccW'(1)) >>> 1;
  assign fin  = AccW'($signed(p1c)) + half;
  assign stat.eval_done = !ebusy;

  // single keyframe: memory data arrives in the cycle after start
  always_ff @(posedge clk) begin
    if (rst) single_d <= 1'b0;
    else     single_d <= cmd.single;
  end

  // horner steps and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ebusy <= 1'b0;
    end else if (cmd.single) begin
      ebusy <= 1'b0;
    end else if (cmd.eval_start) begin
      ebusy <= 1'b1;
      ci    <= 2'd0;
      hstep <= 2'd0;
      acc   <= coa[0];
    end else if (cmd.eval_step && ebusy) begin
      if (hstep == 2'd2) begin
        if (fin > AccW'(64'sh7FFFFFFF))
          result[ci*CoordW +: CoordW] <= 32'h7FFFFFFF;
        else if (fin < -AccW'(64'sh80000000))
          result[ci*CoordW +: CoordW] <= 32'h80000000;
        else
          result[ci*CoordW +: CoordW] <= fin[CoordW-1:0];
        hstep <= 2'd0;
        if (ci == 2'd2) begin
          ebusy <= 1'b0;
        end else begin
          ci  <= ci + 2'd1;
          acc <= coa[ci + 2'd1];
        end
      end else begin
        acc   <= rnd + addend;
        hstep <= hstep + 2'd1;
      end
    end
    if (single_d) result <= p_rdata;
  end

  // assertions
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    cmd.srch_cmp |-> lo <= hi) else $error("search bounds crossed");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step && dbusy |-> dden != '0) else $error("divide by zero");
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(dbusy && ebusy)) else $error("divider and evaluator both busy");

endmodule

// File: rtl/core/catmull_rom_keyframe_interp.sv
// ----------------------------------------------------------------------------
// catmull_rom_keyframe_interp: Catmull-Rom keyframe interpolator top level
// Loads write their slot when accepted; a query runs the binary search, the
// segment time reads and divider setup, the restoring divide, the point reads
// and the Horner multiply steps (one shared multiplier, three coordinates),
// then the result waits in tdata. A single keyframe is answered from slot 0
// with no search. Input is held off until the result is taken.
// Reset (rst, synchronous) clears the count and control; the tables are
// undefined until loaded.
// ----------------------------------------------------------------------------
module catmull_rom_keyframe_interp #(
  parameter int unsigned MaxPoints = crki_pkg::DefMaxPoints
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [8:0]   cfg_wdata,       // point_count
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic         s_axis_tuser,    // action
  // key_index[7:0], key_time[39:8], key_x[71:40], key_y[103:72],
  // key_z[135:104], query_time[167:136]
  input  logic [167:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata     // out_x[31:0], out_y[63:32], out_z[95:64]
);
  import crki_pkg::*;

  logic [CountW-1:0] point_count;
  logic              acc_in, busy, is_query;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  // count register
  always_ff @(posedge clk) begin
    if (rst)         point_count <= '0;
    else if (cfg_we) point_count <= cfg_wdata;
  end

  assign s_axis_tready = !busy;
  assign acc_in   = s_axis_tvalid && s_axis_tready;
  assign is_query = (s_axis_tuser == ActQuery);

  crki_ctrl u_ctrl (
    .clk, .rst,
    .in_go(acc_in && is_query),
    .cnt_zero(point_count == '0),
    .cnt_one(point_count == CountW'(1)),
    .out_taken(m_axis_tready),
    .stat, .cmd, .busy,
    .out_valid(m_axis_tvalid));

  crki_dp #(.MaxPoints(MaxPoints)) u_dp (
    .clk, .rst,
    .load_we(acc_in && !is_query),
    .load_idx(s_axis_tdata[7:0]),
    .load_time(s_axis_tdata[39:8]),
    .load_pt(s_axis_tdata[135:40]),
    .query_time(s_axis_tdata[167:136]),
    .point_count, .cmd, .stat,
    .result(m_axis_tdata));

  // assertions
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready) else $error("input taken while busy");
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open with result pending");
  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    acc_in && point_count == '0 |=> !busy) else $error("query with no keyframes ran");

endmodule

// File: bench/tb_catmull_rom_keyframe_interp.sv
// ----------------------------------------------------------------------------
// tb_catmull_rom_keyframe_interp: self-checking bench of the keyframe interpolator
// Runs phases of point counts (none, one, two, full table, clamped count and
// random sizes). Each phase loads every used slot before any query, then mixes
// queries with stray loads. A local model predicts each answer; the monitor
// compares the answers field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_catmull_rom_keyframe_interp;
  import crki_pkg::*;

  localparam int StallLimit = 20000;
  localparam int DrainWait  = 80;
  localparam int TableDepth = 256;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [8:0]   cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic         s_axis_tuser = 1'b0;
  logic [167:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;

  catmull_rom_keyframe_interp u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // an item is {tdata, tuser}: action in bit 0, tdata fields above it
  logic [168:0] pending_items[$];
  logic [95:0]  expected_points[$];
  int           snd_idle = 11;
  int           rcv_idle = 56;
  bit           hold_sender = 1'b0;
  int           errors = 0;
  int           n_loads = 0, n_queries = 0, n_points = 0, n_phases = 0;
  int           stall_cnt = 0;

  // model state
  logic [31:0]  mdl_time[TableDepth];
  logic [31:0]  mdl_pt[TableDepth][3];
  logic [8:0]   mdl_count = '0;

  function automatic logic [168:0] load_item(logic [7:0] idx, logic [31:0] t,
                                             logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z);
    logic [168:0] d;
    d = '0;
    d[0] = ActLoad;
    d[8:1] = idx;
    d[40:9] = t;
    d[72:41] = x;
    d[104:73] = y;
    d[136:105] = z;
    d[168:137] = $urandom;   // ignored by a load
    return d;
  endfunction

  function automatic logic [168:0] query_item(logic [31:0] qt);
    logic [168:0] d;
    logic [159:0] junk;
    d = '0;
    junk = {$urandom, $urandom, $urandom, $urandom, $urandom};
    d[0] = ActQuery;
    d[136:1] = junk[135:0];  // ignored
    d[168:137] = qt;
    return d;
  endfunction

  // one coordinate of the doubled-coefficient horner cubic
  function automatic logic [31:0] spline_coord(int p0, int p1, int p2, int p3,
                                               longint s);
    longint m0, m1, d, a, b, acc, r;
    m0 = longint'(p2) - longint'(p0);
    m1 = longint'(p3) - longint'(p1);
    d  = longint'(p1) - longint'(p2);
    a  = 4 * d + m0 + m1;
    b  = -6 * d - 2 * m0 - m1;
    acc = a;
    acc = ((acc * s + 32768) >>> 16) + b;
    acc = ((acc * s + 32768) >>> 16) + m0;
    acc = (acc * s + 32768) >>> 16;
    r = longint'(p1) + ((acc + 1) >>> 1);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // apply one accepted item to the model, queue any answer
  task automatic interp_predict(logic [168:0] d);
    int cnt, last, lo, hi, mid, seg, i0, i1, i2;
    logic [31:0] u, t0, t1;
    logic [63:0] num;
    longint s;
    logic [95:0] pt;
    if (d[0] == ActLoad) begin
      n_loads++;
      mdl_time[d[8:1]] = d[40:9];
      mdl_pt[d[8:1]][0] = d[72:41];
      mdl_pt[d[8:1]][1] = d[104:73];
      mdl_pt[d[8:1]][2] = d[136:105];
      return;
    end
    n_queries++;
    cnt = (mdl_count > TableDepth) ? TableDepth : mdl_count;
    if (cnt == 0) return;
    if (cnt == 1) begin
      expected_points.push_back({mdl_pt[0][2], mdl_pt[0][1], mdl_pt[0][0]});
      return;
    end
    u = d[168:137];
    last = cnt - 1;
    lo = 0;
    hi = last;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (mdl_time[mid] < u) lo = mid + 1;
      else hi = mid;
    end
    seg = (lo > 0) ? lo - 1 : 0;
    i0 = (seg > 0) ? seg - 1 : 0;
    i1 = seg + 1;
    i2 = (i1 + 1 > last) ? last : i1 + 1;
    t0 = mdl_time[seg];
    t1 = mdl_time[i1];
    if (u <= t0) s = 0;
    else if (u >= t1) s = 65536;
    else begin
      num = {16'h0, u - t0, 16'h0};
      s = longint'(num / {32'h0, t1 - t0});
    end
    for (int c = 0; c < 3; c++)
      pt[c*32 +: 32] = spline_coord(mdl_pt[i0][c], mdl_pt[seg][c],
                                    mdl_pt[i1][c], mdl_pt[i2][c], s);
    expected_points.push_back(pt);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_items.size() > 0 && !hold_sender && $urandom_range(99) >= snd_idle) begin
        {s_axis_tdata, s_axis_tuser} <= pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(99) >= rcv_idle);
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) mdl_count = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) interp_predict({s_axis_tdata, s_axis_tuser});
      if (m_axis_tvalid && m_axis_tready) begin
        n_points++;
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected out_x", m_axis_tdata[31:0], 32'h0);
        end else begin
          logic [95:0] want;
          want = expected_points.pop_front();
          if (m_axis_tdata[31:0] !== want[31:0])
            report_mismatch("out_x", m_axis_tdata[31:0], want[31:0]);
          if (m_axis_tdata[63:32] !== want[63:32])
            report_mismatch("out_y", m_axis_tdata[63:32], want[63:32]);
          if (m_axis_tdata[95:64] !== want[95:64])
            report_mismatch("out_z", m_axis_tdata[95:64], want[95:64]);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cnt = 0;
      else
        stall_cnt++;
      if (stall_cnt >= StallLimit) begin
        $display("watchdog: no progress for %0d cycles", StallLimit);
        $display("tb_catmull_rom_keyframe_interp: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return $urandom_range(32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_points.size() > 0)
      @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_count(logic [8:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one phase: set the count, fill the used slots, then query
  task automatic run_phase(int cnt, int n_q, int order);
    int used, pushed;
    logic [31:0] t, step, tfirst, tlast, qt;
    logic [31:0] times[TableDepth];
    wait_idle();
    write_count(cnt[8:0]);
    n_phases++;
    used = (cnt > TableDepth) ? TableDepth : cnt;
    step = (used > 1) ? 32'hffff_ffff / used : 32'hffff_ffff;
    t = $urandom_range(step / 2);
    for (int i = 0; i < used; i++) begin
      times[i] = t;
      pending_items.push_back(load_item(i[7:0], t, rand_coord(), rand_coord(), rand_coord()));
      case (order)
        0: t = t + $urandom_range(step, 1);
        1: t = t + ($urandom_range(3) == 0 ? 0 : $urandom_range(step, 1));
        default: t = $urandom;
      endcase
    end
    tfirst = (used > 0) ? times[0] : 0;
    tlast  = (used > 0) ? times[used-1] : 0;
    pushed = 0;
    while (pushed < n_q) begin
      if ($urandom_range(9) == 0) begin
        // stray load into an unused slot keeps the active curve intact
        if (used < TableDepth) begin
          int sl;
          sl = $urandom_range(TableDepth - 1, used);
          pending_items.push_back(load_item(sl[7:0], $urandom, rand_coord(), rand_coord(),
                                            rand_coord()));
        end
      end else begin
        case ($urandom_range(9))
          0: qt = 32'h0;
          1: qt = 32'hffff_ffff;
          2: qt = $urandom;
          3: qt = (used > 0) ? times[$urandom_range(used - 1)] : $urandom;
          default: qt = (tlast > tfirst) ? $urandom_range(tlast, tfirst) : $urandom;
        endcase
        pending_items.push_back(query_item(qt));
        pushed++;
      end
      if (pending_items.size() > 64)
        while (pending_items.size() > 8) @(posedge clk);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: no point, one point, two points, three, full and clamped table
    run_phase(0, 3, 0);
    run_phase(1, 3, 0);
    run_phase(2, 6, 0);
    run_phase(3, 5, 1);
    run_phase(256, 4, 0);
    run_phase(511, 4, 0);

    // sender held off while a phase is queued, then released once no answer is pending
    pending_items.push_back(query_item($urandom));
    wait_idle();
    hold_sender = 1'b1;
    run_phase(4, 6, 0);
    while (expected_points.size() > 0) @(posedge clk);
    hold_sender = 1'b0;

    // random phases, idling profile switches over the run
    while (n_loads + n_queries < 2000) begin
      int c, o;
      if (n_loads + n_queries > 1400) begin
        snd_idle = 0;
        rcv_idle = 0;
      end else if (n_loads + n_queries > 700) begin
        snd_idle = 56;
        rcv_idle = 11;
      end
      case ($urandom_range(11))
        0: c = $urandom_range(1, 0);
        1: c = $urandom_range(511, 256);
        2: c = $urandom_range(255, 32);
        default: c = $urandom_range(16, 2);
      endcase
      o = $urandom_range(5) == 0 ? 2 : ($urandom_range(3) == 0 ? 1 : 0);
      run_phase(c, $urandom_range(60, 20), o);
    end
    wait_idle();

    $display("covered %0d phases: %0d loads, %0d queries, %0d answers checked",
             n_phases, n_loads, n_queries, n_points);
    if (errors == 0) begin
      $display("tb_catmull_rom_keyframe_interp: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_catmull_rom_keyframe_interp: FAIL");
    end
    $finish;
  end

endmodule
